[hdl/tzr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tzr_pkg
// Shared constants and types of the triangle z-buffer rasterizer.
// ----------------------------------------------------------------------------
package tzr_pkg;
    localparam int COLOUR_W = 24;
    localparam int DEPTH_W  = 24;
    localparam int COUNT_W  = 17;
    localparam int COORD_W  = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_FAR = 24'h800000;

    localparam logic [0:0] OP_DRAW = 1'b0;
    localparam logic [0:0] OP_READ = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_SETUP = 8'b00000100,
        ST_EDGE  = 8'b00001000,
        ST_WALK  = 8'b00010000,
        ST_DRAIN = 8'b00100000,
        ST_READ  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;
endpackage
`default_nettype wire

[hdl/triangle_zbuffer_rasterizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer
// Flat-shaded triangle rasterizer with depth test and pixel read-back.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one command per transaction: a draw (three fixed-point
//    vertices, flat depth, colour) or a read of one pixel; s_axis_tuser
//    selects which.
//  - m_axis returns one result per command: read colour/depth, or the count of
//    pixels a draw overwrote.
//  - cfg writes frame_width (index 0) and frame_height (index 1); write only
//    while idle.
//  - Sequence: a read passes READ and OUT before its result is presented. A
//    draw spends SETUP, EDGE, one WALK cycle per pixel of the clipped bounding
//    box (up to MAX_WIDTH*MAX_HEIGHT pixels), DRAIN until the last pixel has
//    left the pipeline, and OUT; an empty box goes from EDGE straight to DRAIN.
//    The walk rate is set by the single read-modify-write loop over the depth
//    and colour memories.
//  - Throughput: one command at a time; s_axis_tready rises again in the
//    cycle after the previous result transaction.
//  - Reset: after aresetn the block sweeps all 2**(XW+YW) entries of both
//    memories (65536 with the default sizes), one entry a cycle, with s_axis_tready low.
//  - A held result waits in the output register while m_axis_tready is low;
//    the next command is taken once that result has left.
//  - Consecutive pixels of a walk never share an entry; the write forwarded
//    from the previous cycle covers a read issued on the edge of that write.
// ----------------------------------------------------------------------------
module triangle_zbuffer_rasterizer #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int CHANNELS     = 3,
    parameter int CHANNEL_BITS = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    // triangle_depth, triangle_colour, read_x, read_y (160 bits)
    input  wire [159:0] s_axis_tdata,
    // operation
    input  wire [0:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pixel_colour, pixel_depth, pixels_written (65 of 72 bits used)
    output logic [71:0] m_axis_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire [8:0]   cfg_data
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CBITS = (CHANNELS * CHANNEL_BITS > 24) ? 24 : CHANNELS * CHANNEL_BITS;
    localparam logic [23:0] CMASK = 24'((64'd1 << CBITS) - 64'd1);
    localparam int PW    = 20;  // pixel coordinate in 1/16 units, signed
    localparam int EW    = 18;  // edge difference
    localparam int CW    = 38;  // cross product

    // input unpack
    wire        in_op    = s_axis_tuser[0];
    wire signed [15:0] in_x0 = s_axis_tdata[15:0];
    wire signed [15:0] in_y0 = s_axis_tdata[31:16];
    wire signed [15:0] in_x1 = s_axis_tdata[47:32];
    wire signed [15:0] in_y1 = s_axis_tdata[63:48];
    wire signed [15:0] in_x2 = s_axis_tdata[79:64];
    wire signed [15:0] in_y2 = s_axis_tdata[95:80];
    wire [23:0] in_depth  = s_axis_tdata[119:96];
    wire [23:0] in_colour = s_axis_tdata[143:120];
    wire [7:0]  in_rx     = s_axis_tdata[151:144];
    wire [7:0]  in_ry     = s_axis_tdata[159:152];

    tzr_pkg::state_t state_reg, state_next;

    logic [8:0] fw_reg, fh_reg;
    logic signed [15:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [23:0] depth_reg, colour_reg;
    logic [7:0]  rx_reg, ry_reg;
    logic        rd_in_reg;
    logic signed [EW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg;
    logic signed [CW-1:0] c_reg;
    logic [XW:0] xmin_reg, xmax_reg, x_reg;
    logic [YW:0] ymax_reg, y_reg;
    logic        empty_reg;
    logic [AW:0] clr_reg;
    logic [16:0] count_reg;
    logic [71:0] out_reg;
    logic        out_valid_reg;

    // pipeline stage 1: address issued, cross products computed
    logic        p1_valid_reg;
    logic [AW-1:0] p1_addr_reg;
    logic        p1_in_reg;
    // pipeline stage 2 write-back forwarding
    logic        wb_en_reg;
    logic [AW-1:0] wb_addr_reg;

    assign s_axis_tready = (state_reg == tzr_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    wire s_fire = s_axis_tvalid && s_axis_tready;

    // bounding box helpers
    function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction
    function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic signed [15:0] mnx, mxx, mny, mxy;
    logic signed [12:0] cxmin, cxmax, cymin, cymax;  // ceil/floor in pixels
    logic [9:0]  fwc, fhc;
    always_comb begin
        mnx = min3(x0_reg, x1_reg, x2_reg);
        mxx = max3(x0_reg, x1_reg, x2_reg);
        mny = min3(y0_reg, y1_reg, y2_reg);
        mxy = max3(y0_reg, y1_reg, y2_reg);
        cxmin = 13'(mnx >>> 4) + 13'(mnx[3:0] != 4'd0);
        cxmax = 13'(mxx >>> 4);
        cymin = 13'(mny >>> 4) + 13'(mny[3:0] != 4'd0);
        cymax = 13'(mxy >>> 4);
        fwc = (32'(fw_reg) > MAX_WIDTH)  ? 10'(MAX_WIDTH)  : {1'b0, fw_reg};
        fhc = (32'(fh_reg) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : {1'b0, fh_reg};
    end

    logic signed [13:0] bxmin, bxmax, bymin, bymax;
    always_comb begin
        bxmin = (cxmin < 0) ? 14'sd0 : 14'(cxmin);
        bymin = (cymin < 0) ? 14'sd0 : 14'(cymin);
        bxmax = (14'(cxmax) > $signed({4'd0, fwc}) - 14'sd1) ?
                $signed({4'd0, fwc}) - 14'sd1 : 14'(cxmax);
        bymax = (14'(cymax) > $signed({4'd0, fhc}) - 14'sd1) ?
                $signed({4'd0, fhc}) - 14'sd1 : 14'(cymax);
    end

    // per-pixel coverage
    logic signed [PW-1:0] e2x, e2y;
    logic signed [CW-1:0] su, sv, ssum;
    logic covered;
    always_comb begin
        e2x  = $signed({{(PW-XW-5){1'b0}}, x_reg, 4'd0}) - PW'(x0_reg);
        e2y  = $signed({{(PW-YW-5){1'b0}}, y_reg, 4'd0}) - PW'(y0_reg);
        su   = CW'(e2x) * CW'(e1y_reg) - CW'(e2y) * CW'(e1x_reg);
        sv   = CW'(e0x_reg) * CW'(e2y) - CW'(e0y_reg) * CW'(e2x);
        ssum = su + sv;
        if (c_reg == '0) covered = 1'b1;
        else if (c_reg > 0) covered = (su >= 0) && (sv >= 0) && (ssum < c_reg);
        else covered = (su <= 0) && (sv <= 0) && (ssum > c_reg);
    end

    // memories
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [23:0]   wr_colour, wr_depth, rd_colour, rd_depth;

    tzr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_colour (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_colour),
        .rd_addr(rd_addr), .rd_data(rd_colour)
    );
    tzr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_depth (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_depth),
        .rd_addr(rd_addr), .rd_data(rd_depth)
    );

    wire [AW-1:0] walk_addr = {y_reg[YW-1:0], x_reg[XW-1:0]};
    wire walk_go = (state_reg == tzr_pkg::ST_WALK);
    wire x_last  = (x_reg == xmax_reg);
    wire y_last  = (y_reg == ymax_reg);

    // depth compare with forwarding from last cycle's write
    wire [23:0] cur_depth = (wb_en_reg && wb_addr_reg == p1_addr_reg) ? depth_reg : rd_depth;
    wire do_write = p1_valid_reg && p1_in_reg && ($signed(depth_reg) > $signed(cur_depth));

    always_comb begin
        rd_addr = walk_go ? walk_addr : {ry_reg[YW-1:0], rx_reg[XW-1:0]};
        if (state_reg == tzr_pkg::ST_CLEAR) begin
            wr_en = 1'b1; wr_addr = clr_reg[AW-1:0];
            wr_colour = '0; wr_depth = tzr_pkg::DEPTH_FAR;
        end else begin
            wr_en = do_write; wr_addr = p1_addr_reg;
            wr_colour = colour_reg; wr_depth = depth_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tzr_pkg::ST_CLEAR: if (clr_reg == (AW+1)'(DEPTH - 1))
                                   state_next = tzr_pkg::ST_IDLE;
            tzr_pkg::ST_IDLE:  if (s_fire) state_next = (in_op == tzr_pkg::OP_READ) ?
                                          tzr_pkg::ST_READ : tzr_pkg::ST_SETUP;
            tzr_pkg::ST_SETUP: state_next = tzr_pkg::ST_EDGE;
            tzr_pkg::ST_EDGE:  state_next = empty_reg ? tzr_pkg::ST_DRAIN : tzr_pkg::ST_WALK;
            tzr_pkg::ST_WALK:  if (x_last && y_last) state_next = tzr_pkg::ST_DRAIN;
            tzr_pkg::ST_DRAIN: if (!p1_valid_reg) state_next = tzr_pkg::ST_OUT;
            tzr_pkg::ST_READ:  state_next = tzr_pkg::ST_OUT;
            tzr_pkg::ST_OUT:   state_next = tzr_pkg::ST_IDLE;
            default:           state_next = tzr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tzr_pkg::ST_CLEAR;
            clr_reg <= '0;
            fw_reg <= 9'd256;
            fh_reg <= 9'd256;
            out_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            wb_en_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tzr_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tzr_pkg::CFG_FRAME_WIDTH) fw_reg <= cfg_data;
                else fh_reg <= cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
            if (state_reg == tzr_pkg::ST_OUT) out_valid_reg <= 1'b1;
            p1_valid_reg <= walk_go;
            wb_en_reg <= do_write;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x0_reg <= in_x0; y0_reg <= in_y0; x1_reg <= in_x1; y1_reg <= in_y1;
            x2_reg <= in_x2; y2_reg <= in_y2;
            depth_reg <= in_depth; colour_reg <= in_colour & CMASK;
            rx_reg <= in_rx; ry_reg <= in_ry;
            rd_in_reg <= (32'(in_rx) < MAX_WIDTH) && (32'(in_ry) < MAX_HEIGHT);
            count_reg <= '0;
        end
        if (state_reg == tzr_pkg::ST_SETUP) begin
            e0x_reg <= EW'(x2_reg) - EW'(x0_reg);
            e0y_reg <= EW'(y2_reg) - EW'(y0_reg);
            e1x_reg <= EW'(x1_reg) - EW'(x0_reg);
            e1y_reg <= EW'(y1_reg) - EW'(y0_reg);
            xmin_reg <= (XW+1)'(bxmin); xmax_reg <= (XW+1)'(bxmax);
            ymax_reg <= (YW+1)'(bymax);
            x_reg <= (XW+1)'(bxmin); y_reg <= (YW+1)'(bymin);
            empty_reg <= (bxmax < bxmin) || (bymax < bymin);
        end
        if (state_reg == tzr_pkg::ST_EDGE) begin
            c_reg <= CW'(e0x_reg) * CW'(e1y_reg) - CW'(e0y_reg) * CW'(e1x_reg);
        end
        if (walk_go) begin
            p1_addr_reg <= walk_addr;
            p1_in_reg   <= covered;
            if (x_last) begin
                x_reg <= xmin_reg;
                y_reg <= y_reg + 1'b1;
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
        wb_addr_reg <= p1_addr_reg;
        if (do_write) count_reg <= count_reg + 1'b1;
    end

    // read path tracking: read data issued in ST_READ arrives in ST_OUT
    logic rd_op_reg;
    always_ff @(posedge aclk) begin
        if (s_fire) rd_op_reg <= in_op;
    end

    logic [71:0] out_next;
    always_comb begin
        out_next = '0;
        if (rd_op_reg) begin
            if (rd_in_reg) out_next[47:0] = {rd_depth, rd_colour};
        end else begin
            out_next[64:48] = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == tzr_pkg::ST_OUT) out_reg <= out_next;
    end

    // ---------------------------------------------------------------- checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !out_valid_reg)
        else $error("accept while result pending");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tzr_pkg::ST_IDLE) |-> !wr_en)
        else $error("memory write while idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule
`default_nettype wire

[hdl/tzr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tzr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tzr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
